// ===== src/lasc_pkg.sv =====
// Shared constants for the local alignment score core.
// Item kinds, register indexes, register reset values and score limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lasc_pkg;

	localparam int MAX_LEN_DEF = 1024;

	localparam int SYM_W   = 8;
	localparam int SCORE_W = 14;
	localparam int KIND_W  = 2;
	localparam int WIDE_W  = 16;

	localparam logic [SCORE_W-1:0] CELL_MAX = 14'd16383;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_APPEND_A = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND_B = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPUTE  = 2'd2;

	// register indexes (word address)
	localparam logic [1:0] REG_MATCH    = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_GAP      = 2'd2;

	localparam logic [3:0] MATCH_RST    = 4'd3;
	localparam logic [4:0] MISMATCH_RST = 5'b11101;
	localparam logic [3:0] GAP_RST      = 4'd2;

endpackage : lasc_pkg

`default_nettype wire

// ===== src/local_alignment_score_core.sv =====
// Smith-Waterman local alignment score with linear gap penalty.
// Appends: a new item is taken every cycle while the core is idle; in_ready is low otherwise.
// A compute transaction walks the LA x LB matrix (LA, LB = sequence lengths) row by row,
// one matrix cell per cycle through the row-score memory, with a setup state before and a
// drain state after each row, then waits in finish while an earlier result is unaccepted;
// an empty sequence goes straight to finish.
// Reset is asynchronous: lengths, drop flag, registers and control clear; memories do not.
// Uses lasc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module local_alignment_score_core
	import lasc_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// APB configuration
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,
	// input items
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [SYM_W-1:0]    symbol,
	// results
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [SCORE_W-1:0]  best_score,
	output logic                     overflowed
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RSTART = 3'd1;
	localparam logic [2:0] ST_RUN    = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	typedef logic [LW-1:0] len_t;
	typedef logic [AW-1:0] addr_t;

	// config registers
	logic [3:0] match_q;
	logic [4:0] mismatch_q;
	logic [3:0] gap_q;

	logic [2:0] state_q;
	len_t       la_q, lb_q, i_q;
	addr_t      k_q, k_s1;
	logic       valid_s1;
	logic       drop_q;

	logic [SCORE_W-1:0] diag_q, left_q, best_q;
	logic [SCORE_W-1:0] best_score_q;
	logic               overflowed_q;
	logic               out_valid_q;

	// memories
	logic [SYM_W-1:0]   seq_a_mem [MAX_LEN];
	logic [SYM_W-1:0]   seq_b_mem [MAX_LEN];
	logic [SCORE_W-1:0] row_mem   [MAX_LEN];
	logic [SYM_W-1:0]   a_rd_q, b_rd_q;
	logic [SCORE_W-1:0] row_rd_q;

	logic in_acc, cfg_wr, a_full, b_full, a_we, b_we, out_free, last_issue, last_row;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign a_full   = (la_q == len_t'(MAX_LEN));
	assign b_full   = (lb_q == len_t'(MAX_LEN));
	assign a_we     = in_acc && (kind == KIND_APPEND_A) && !a_full;
	assign b_we     = in_acc && (kind == KIND_APPEND_B) && !b_full;
	assign out_free = !out_valid_q || out_ready;
	assign last_issue = ((len_t'(k_q) + len_t'(1)) == lb_q);
	assign last_row   = ((i_q + len_t'(1)) == la_q);

	assign out_valid  = out_valid_q;
	assign best_score = best_score_q;
	assign overflowed = overflowed_q;

	always_comb begin
		unique case (paddr[3:2])
			REG_MATCH:    prdata = {28'd0, match_q};
			REG_MISMATCH: prdata = {27'd0, mismatch_q};
			REG_GAP:      prdata = {28'd0, gap_q};
			default:      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= MATCH_RST;
			mismatch_q <= MISMATCH_RST;
			gap_q      <= GAP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MATCH:    match_q    <= pwdata[3:0];
				REG_MISMATCH: mismatch_q <= pwdata[4:0];
				REG_GAP:      gap_q      <= pwdata[3:0];
				default:      ;
			endcase
		end
	end

	// sequence and row stores, read every cycle
	always_ff @(posedge clk) begin
		if (a_we)
			seq_a_mem[la_q[AW-1:0]] <= symbol;
		a_rd_q <= seq_a_mem[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (b_we)
			seq_b_mem[lb_q[AW-1:0]] <= symbol;
		b_rd_q <= seq_b_mem[k_q];
	end

	// cell update
	logic signed [WIDE_W-1:0] sub_v, up_v, c_v, l_v, u_v, h0_v, h1_v, h2_v;
	logic [SCORE_W-1:0]       h_v;

	always_comb begin
		sub_v = (a_rd_q == b_rd_q) ? $signed({12'd0, match_q})
		                           : $signed({{11{mismatch_q[4]}}, mismatch_q});
		up_v  = (i_q == '0) ? '0 : $signed({2'b00, row_rd_q});
		c_v   = $signed({2'b00, diag_q}) + sub_v;
		l_v   = $signed({2'b00, left_q}) - $signed({12'd0, gap_q});
		u_v   = up_v - $signed({12'd0, gap_q});
		h0_v  = (c_v > 0) ? c_v : '0;
		h1_v  = (l_v > h0_v) ? l_v : h0_v;
		h2_v  = (u_v > h1_v) ? u_v : h1_v;
		if (h2_v > $signed({2'b00, CELL_MAX}))
			h_v = CELL_MAX;
		else
			h_v = h2_v[SCORE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			row_mem[k_s1] <= h_v;
		row_rd_q <= row_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN)
			k_s1 <= k_q;
		if (state_q == ST_RSTART) begin
			diag_q <= '0;
			left_q <= '0;
		end else if (valid_s1) begin
			diag_q <= up_v[SCORE_W-1:0];
			left_q <= h_v;
		end
		if (state_q == ST_FINISH && out_free) begin
			best_score_q <= best_q;
			overflowed_q <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			la_q        <= '0;
			lb_q        <= '0;
			i_q         <= '0;
			k_q         <= '0;
			valid_s1    <= 1'b0;
			drop_q      <= 1'b0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			valid_s1 <= (state_q == ST_RUN);
			if (valid_s1 && h_v > best_q)
				best_q <= h_v;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (kind)
							KIND_APPEND_A: begin
								if (a_full) drop_q <= 1'b1;
								else        la_q   <= la_q + len_t'(1);
							end
							KIND_APPEND_B: begin
								if (b_full) drop_q <= 1'b1;
								else        lb_q   <= lb_q + len_t'(1);
							end
							KIND_COMPUTE: begin
								best_q <= '0;
								i_q    <= '0;
								if (la_q == '0 || lb_q == '0) state_q <= ST_FINISH;
								else                          state_q <= ST_RSTART;
							end
							default: ;
						endcase
					end
				end
				ST_RSTART: begin
					k_q     <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					k_q <= k_q + addr_t'(1);
					if (last_issue)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (last_row) begin
						state_q <= ST_FINISH;
					end else begin
						i_q     <= i_q + len_t'(1);
						state_q <= ST_RSTART;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						la_q        <= '0;
						lb_q        <= '0;
						drop_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a cell is computed only in the cycle after its read was issued
	a_cell_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q) == ST_RUN)
		else $error("cell computed without a read issue");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> len_t'(k_q) < lb_q)
		else $error("column index past second sequence");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RSTART || state_q == ST_RUN) |-> i_q < la_q)
		else $error("row index past first sequence");

	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (la_q == '0 && lb_q == '0 && !drop_q
			&& out_valid_q))
		else $error("report did not clear sequences");

endmodule : local_alignment_score_core

`default_nettype wire
